>>> rtl/color_slot_resolver_fifo_cache_assert.svh
// Assertion macros used by the color slot resolver back end (cslr_back).
`ifndef COLOR_SLOT_RESOLVER_FIFO_CACHE_ASSERT_SVH
`define COLOR_SLOT_RESOLVER_FIFO_CACHE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSLR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/cslr_pkg.sv
package cslr_pkg;

	localparam logic [2:0] MODE_BASIC   = 3'd0;
	localparam logic [2:0] MODE_BRIGHT  = 3'd1;
	localparam logic [2:0] MODE_INDEXED = 3'd2;
	localparam logic [2:0] MODE_RGB     = 3'd3;

	localparam logic [1:0] TGT_PALETTE = 2'd0;
	localparam logic [1:0] TGT_INDEXED = 2'd1;
	localparam logic [1:0] TGT_RGB     = 2'd2;
	localparam logic [1:0] TGT_WHITE   = 2'd3;

	// Work classes handed from the front end to the back end.
	localparam logic [1:0] OP_DONE    = 2'd0;
	localparam logic [1:0] OP_INDEXED = 2'd1;
	localparam logic [1:0] OP_RGB     = 2'd2;

	localparam logic [7:0] INDEX_CUBE_FIRST = 8'd16;
	localparam logic [7:0] INDEX_GRAY_FIRST = 8'd232;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] code;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} req_t;

	typedef struct packed {
		logic [1:0] target;
		logic [7:0] entry_index;
		logic       allocate;
		logic       release_res;
		logic [7:0] fill_red;
		logic [7:0] fill_green;
		logic [7:0] fill_blue;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  target;
		logic [7:0]  index;
		logic [23:0] key;
	} cmd_t;

endpackage

>>> rtl/cslr_chan_if.sv
interface cslr_chan_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/color_slot_resolver_fifo_cache.sv
// Color slot resolver. Each request on req yields exactly one transfer on rsp, in order.
// After reset the back end clears its 256 indexed-entry flags and takes no command
// meanwhile; the front classifier and the two-entry command queue already accept
// requests. With the queue empty and the back end idle, a palette or white request
// passes through the queue entry register and then the result register, and back to
// back such requests sustain one item per cycle while rsp is ready; an indexed request
// also passes through the registered read of its flag. A direct rgb request scans the
// RGB_SLOTS-entry key memory one entry per cycle through its single registered read
// port until a valid slot matches or every slot has missed; on a miss the slot under
// the FIFO pointer is rewritten. The back end takes its next command only when it is
// idle and the result register is empty or is emptied in the same cycle; the queue
// holds up to two requests while it waits.
module color_slot_resolver_fifo_cache #(
	parameter int RGB_SLOTS = 64
) (
	input logic         clk,
	input logic         arst_n,
	cslr_chan_if.sink   req,
	cslr_chan_if.source rsp
);
	import cslr_pkg::*;

	cslr_chan_if #(.data_t(cmd_t)) front_cmd ();
	cslr_chan_if #(.data_t(cmd_t)) back_cmd ();

	cslr_front u_front (
		.req (req),
		.cmd (front_cmd)
	);

	cslr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_cmd),
		.pop    (back_cmd)
	);

	cslr_back #(.RGB_SLOTS(RGB_SLOTS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (back_cmd),
		.rsp    (rsp)
	);
endmodule

>>> rtl/cslr_front.sv
module cslr_front (
	cslr_chan_if.sink   req,
	cslr_chan_if.source cmd
);
	import cslr_pkg::*;

	cmd_t cmd_d;

	assign req.ready = cmd.ready;
	assign cmd.valid = req.valid;
	assign cmd.data  = cmd_d;

	// Palette and white requests are resolved here; cache work is passed on.
	always_comb begin
		cmd_d.op     = OP_DONE;
		cmd_d.target = TGT_WHITE;
		cmd_d.index  = 8'd0;
		cmd_d.key    = {req.data.red_in, req.data.green_in, req.data.blue_in};
		unique case (req.data.mode)
			MODE_BASIC: begin
				if (req.data.code >= 8'd30 && req.data.code <= 8'd37) begin
					cmd_d.target = TGT_PALETTE;
					cmd_d.index  = req.data.code - 8'd30;
				end else if (req.data.code >= 8'd40 && req.data.code <= 8'd47) begin
					cmd_d.target = TGT_PALETTE;
					cmd_d.index  = req.data.code - 8'd40;
				end
			end
			MODE_BRIGHT: begin
				if (req.data.code >= 8'd90 && req.data.code <= 8'd97) begin
					cmd_d.target = TGT_PALETTE;
					cmd_d.index  = req.data.code - 8'd82;
				end else if (req.data.code >= 8'd100 && req.data.code <= 8'd107) begin
					cmd_d.target = TGT_PALETTE;
					cmd_d.index  = req.data.code - 8'd92;
				end
			end
			MODE_INDEXED: begin
				cmd_d.index = req.data.code;
				if (req.data.code < INDEX_CUBE_FIRST) begin
					cmd_d.target = TGT_PALETTE;
				end else begin
					cmd_d.op     = OP_INDEXED;
					cmd_d.target = TGT_INDEXED;
				end
			end
			MODE_RGB: begin
				cmd_d.op     = OP_RGB;
				cmd_d.target = TGT_RGB;
			end
			default: begin
				cmd_d.op = OP_DONE;
			end
		endcase
	end
endmodule

>>> rtl/cslr_queue.sv
module cslr_queue (
	input logic         clk,
	input logic         arst_n,
	cslr_chan_if.sink   push,
	cslr_chan_if.source pop
);
	import cslr_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push.ready = (count_q != 2'd2);
	assign pop.valid  = (count_q != 2'd0);
	assign pop.data   = entry_q[rd_ptr_q];
	assign do_push    = push.valid && push.ready;
	assign do_pop     = pop.valid && pop.ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule

>>> rtl/cslr_back.sv
module cslr_back #(
	parameter int RGB_SLOTS = 64
) (
	input logic         clk,
	input logic         arst_n,
	cslr_chan_if.sink   cmd,
	cslr_chan_if.source rsp
);
	import cslr_pkg::*;
	`include "color_slot_resolver_fifo_cache_assert.svh"

	localparam int IDX_W = (RGB_SLOTS > 1) ? $clog2(RGB_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RGB_SLOTS - 1);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FILL  = 2'd2;
	localparam logic [1:0] ST_CLEAR = 2'd3;
	localparam logic [7:0] LAST_INDEX = 8'd255;

	logic [1:0]       state_q;
	logic             idx_filled_mem [256];
	logic [7:0]       clr_addr_q;
	logic [7:0]       idx_q;
	logic             filled_s1;
	logic [23:0]      key_mem [RGB_SLOTS];
	logic             wrapped_q;
	logic [IDX_W-1:0] next_slot_q;
	logic [IDX_W-1:0] rd_addr_q;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [23:0]      rd_key_s1;
	logic             rd_vld_s1;
	logic             issue_q;
	logic [23:0]      key_q;
	rsp_t             out_q;
	rsp_t             out_d;
	logic             out_valid_q;
	logic             out_free;
	logic             do_pop;
	logic             slot_valid;
	logic             hit;
	logic             miss;
	logic             scan_done;
	logic             produce;
	logic             busy;
	logic [23:0]      fill_color;

	// Color of a newly used indexed entry: a 6x6x6 cube or a gray ramp.
	function automatic logic [7:0] cube_level(input logic [2:0] digit);
		logic [7:0] level;
		begin
			case (digit)
				3'd0: level = 8'd0;
				3'd1: level = 8'd95;
				3'd2: level = 8'd135;
				3'd3: level = 8'd175;
				3'd4: level = 8'd215;
				default: level = 8'd255;
			endcase
			return level;
		end
	endfunction

	function automatic logic [23:0] indexed_fill(input logic [7:0] code);
		logic [7:0] c;
		logic [7:0] rem;
		logic [2:0] dr;
		logic [2:0] dg;
		logic [2:0] db;
		logic [7:0] gray;
		logic [7:0] step;
		begin
			c = code - INDEX_CUBE_FIRST;
			dr = 3'(c >= 8'd36) + 3'(c >= 8'd72) + 3'(c >= 8'd108) + 3'(c >= 8'd144)
				+ 3'(c >= 8'd180);
			rem = c - 8'(dr) * 8'd36;
			dg = 3'(rem >= 8'd6) + 3'(rem >= 8'd12) + 3'(rem >= 8'd18) + 3'(rem >= 8'd24)
				+ 3'(rem >= 8'd30);
			db = 3'(rem - 8'(dg) * 8'd6);
			step = code - INDEX_GRAY_FIRST;
			gray = 8'd8 + (step << 3) + (step << 1);
			if (code >= INDEX_GRAY_FIRST) begin
				return {gray, gray, gray};
			end
			return {cube_level(dr), cube_level(dg), cube_level(db)};
		end
	endfunction

	// Slots fill in FIFO order and are never freed, so a slot holds a key when the
	// pointer has already passed it or has wrapped once.
	assign slot_valid = wrapped_q || (rd_idx_s1 < next_slot_q);
	assign out_free   = !out_valid_q || rsp.ready;
	assign cmd.ready  = (state_q == ST_IDLE) && out_free;
	assign do_pop     = cmd.valid && cmd.ready;
	assign hit        = rd_vld_s1 && slot_valid && (rd_key_s1 == key_q);
	assign miss       = rd_vld_s1 && !hit && (rd_idx_s1 == LAST_SLOT);
	assign scan_done  = (state_q == ST_SCAN) && (hit || miss);
	assign produce    = (do_pop && cmd.data.op == OP_DONE) || scan_done || (state_q == ST_FILL);
	assign busy       = (state_q == ST_SCAN) || (state_q == ST_FILL);
	assign fill_color = indexed_fill(idx_q);
	assign rsp.valid  = out_valid_q;
	assign rsp.data   = out_q;

	always_comb begin
		out_d = '0;
		if (scan_done) begin
			out_d.target = TGT_RGB;
			if (hit) begin
				out_d.entry_index = 8'(rd_idx_s1);
			end else begin
				out_d.entry_index = 8'(next_slot_q);
				out_d.allocate    = 1'b1;
				out_d.release_res = wrapped_q;
				out_d.fill_red    = key_q[23:16];
				out_d.fill_green  = key_q[15:8];
				out_d.fill_blue   = key_q[7:0];
			end
		end else if (state_q == ST_FILL) begin
			out_d.target      = TGT_INDEXED;
			out_d.entry_index = idx_q;
			if (!filled_s1) begin
				out_d.allocate   = 1'b1;
				out_d.fill_red   = fill_color[23:16];
				out_d.fill_green = fill_color[15:8];
				out_d.fill_blue  = fill_color[7:0];
			end
		end else begin
			out_d.target      = cmd.data.target;
			out_d.entry_index = cmd.data.index;
		end
	end

	// Indexed-entry flags: cleared one entry per cycle after reset, then one
	// registered read when a command is taken and one write as an indexed result is made.
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			idx_filled_mem[clr_addr_q] <= 1'b0;
		end else if (state_q == ST_FILL) begin
			idx_filled_mem[idx_q] <= 1'b1;
		end
		if (do_pop) begin
			filled_s1 <= idx_filled_mem[cmd.data.index];
		end
	end

	// Key store: one write on a miss, one registered read per scan cycle.
	always_ff @(posedge clk) begin
		if (miss) begin
			key_mem[next_slot_q] <= key_q;
		end
		rd_key_s1 <= key_mem[rd_addr_q];
		rd_idx_s1 <= rd_addr_q;
		if (do_pop) begin
			key_q <= cmd.data.key;
			idx_q <= cmd.data.index;
		end
		if (produce) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			wrapped_q   <= 1'b0;
			next_slot_q <= '0;
			rd_addr_q   <= '0;
			rd_vld_s1   <= 1'b0;
			issue_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue_q && !hit;
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 8'd1;
					if (clr_addr_q == LAST_INDEX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (do_pop && cmd.data.op == OP_RGB) begin
						state_q   <= ST_SCAN;
						issue_q   <= 1'b1;
						rd_addr_q <= '0;
					end else if (do_pop && cmd.data.op == OP_INDEXED) begin
						state_q <= ST_FILL;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (issue_q) begin
				rd_addr_q <= rd_addr_q + 1'b1;
				if (rd_addr_q == LAST_SLOT || hit) begin
					issue_q <= 1'b0;
				end
			end
			if (miss) begin
				if (next_slot_q == LAST_SLOT) begin
					next_slot_q <= '0;
					wrapped_q   <= 1'b1;
				end else begin
					next_slot_q <= next_slot_q + 1'b1;
				end
			end
			if (produce) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`CSLR_ASSERT_SAME(a_busy_out_empty, clk, arst_n, busy, !out_valid_q, "result held while busy")
	`CSLR_ASSERT_NEXT(a_miss_valid, clk, arst_n, miss, wrapped_q || next_slot_q != '0, "slot not valid")
	`CSLR_ASSERT_NEXT(a_slot_holds, clk, arst_n, !miss, $stable(next_slot_q), "pointer moved")
	`CSLR_ASSERT_SAME(a_lookup_in_scan, clk, arst_n, rd_vld_s1 || issue_q, state_q == ST_SCAN, "stray read")
	`CSLR_ASSERT_SAME(a_clear_no_pop, clk, arst_n, state_q == ST_CLEAR, !cmd.ready, "pop during clear")
endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cslr_pkg::*;

	localparam int RGB_SLOTS = 64;
	localparam logic [2:0] MODE_OTHER = 3'd4;
	localparam int RANDOM_PER_PHASE = 125;
	localparam int STALL_LIMIT = 3000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		req_t stim;
		logic has_rsp;
		rsp_t rsp;
	} color_row_t;

	typedef struct packed {
		logic has_rsp;
		rsp_t rsp;
	} given_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	cslr_chan_if #(.data_t(req_t)) req_ch ();
	cslr_chan_if #(.data_t(rsp_t)) rsp_ch ();

	color_slot_resolver_fifo_cache #(.RGB_SLOTS(RGB_SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #6 clk = ~clk;

	// Shadow copy of the block's lookup state.
	logic [255:0] index_seen;
	logic [23:0] slot_key [RGB_SLOTS];
	logic slot_valid [RGB_SLOTS];
	int fifo_ptr;

	rsp_t pending_rsp_q[$];
	given_rsp_t given_rsp_q[$];
	logic [23:0] color_pool [96];
	color_row_t color_table [24];

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int sent_count = 0;
	int received_count = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	function automatic logic [7:0] cube_level(input int n);
		case (n)
		0: return 8'd0;
		1: return 8'd95;
		2: return 8'd135;
		3: return 8'd175;
		4: return 8'd215;
		default: return 8'd255;
		endcase
	endfunction

	function automatic rsp_t resolve_color(input req_t r);
		rsp_t o;
		logic [23:0] key;
		int hit;
		int c;
		int n;
		o = '0;
		o.target = TGT_WHITE;
		key = {r.red_in, r.green_in, r.blue_in};
		hit = -1;
		c = int'(r.code);
		case (r.mode)
		MODE_BASIC: begin
			if (c >= 30 && c <= 37) begin
				o.target = TGT_PALETTE;
				o.entry_index = 8'(c - 30);
			end else if (c >= 40 && c <= 47) begin
				o.target = TGT_PALETTE;
				o.entry_index = 8'(c - 40);
			end
		end
		MODE_BRIGHT: begin
			if (c >= 90 && c <= 97) begin
				o.target = TGT_PALETTE;
				o.entry_index = 8'(c - 90 + 8);
			end else if (c >= 100 && c <= 107) begin
				o.target = TGT_PALETTE;
				o.entry_index = 8'(c - 100 + 8);
			end
		end
		MODE_INDEXED: begin
			o.entry_index = r.code;
			if (c < 16) begin
				o.target = TGT_PALETTE;
			end else begin
				o.target = TGT_INDEXED;
				if (!index_seen[c]) begin
					index_seen[c] = 1'b1;
					o.allocate = 1'b1;
					if (c < 232) begin
						n = c - 16;
						o.fill_red = cube_level(n / 36);
						o.fill_green = cube_level((n / 6) % 6);
						o.fill_blue = cube_level(n % 6);
					end else begin
						o.fill_red = 8'(8 + 10 * (c - 232));
						o.fill_green = o.fill_red;
						o.fill_blue = o.fill_red;
					end
				end
			end
		end
		MODE_RGB: begin
			o.target = TGT_RGB;
			for (int i = 0; i < RGB_SLOTS; i++)
				if (hit < 0 && slot_valid[i] && slot_key[i] == key)
					hit = i;
			if (hit >= 0) begin
				o.entry_index = 8'(hit);
			end else begin
				// Miss: the slot under the FIFO pointer is reused.
				o.entry_index = 8'(fifo_ptr);
				o.allocate = 1'b1;
				o.release_res = slot_valid[fifo_ptr];
				o.fill_red = r.red_in;
				o.fill_green = r.green_in;
				o.fill_blue = r.blue_in;
				slot_key[fifo_ptr] = key;
				slot_valid[fifo_ptr] = 1'b1;
				fifo_ptr = (fifo_ptr + 1) % RGB_SLOTS;
			end
		end
		default: begin
		end
		endcase
		return o;
	endfunction

	function automatic color_row_t make_row(input logic [2:0] mode, input logic [7:0] code,
			input logic [23:0] rgb, input logic has_rsp, input logic [1:0] tgt,
			input logic [7:0] idx, input logic alloc, input logic rel,
			input logic [23:0] fill);
		color_row_t row;
		row.stim = {mode, code, rgb};
		row.has_rsp = has_rsp;
		row.rsp = {tgt, idx, alloc, rel, fill};
		return row;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int pick;
		r.mode = 3'($urandom_range(7));
		r.code = 8'($urandom);
		{r.red_in, r.green_in, r.blue_in} = 24'($urandom);
		pick = $urandom_range(99);
		if (pick < 12) begin
			r.mode = MODE_BASIC;
			if ($urandom_range(9) < 7)
				r.code = 8'($urandom_range(47, 30));
		end else if (pick < 24) begin
			r.mode = MODE_BRIGHT;
			if ($urandom_range(9) < 7)
				r.code = 8'($urandom_range(107, 90));
		end else if (pick < 50) begin
			r.mode = MODE_INDEXED;
		end else if (pick < 85) begin
			r.mode = MODE_RGB;
			// Mostly a reused color so that hits and evictions both occur.
			if ($urandom_range(9) < 7)
				{r.red_in, r.green_in, r.blue_in} = color_pool[$urandom_range(95)];
		end else begin
			r.mode = 3'($urandom_range(7, MODE_OTHER));
		end
		return r;
	endfunction

	task automatic send_request(input req_t r, input logic has_rsp, input rsp_t rsp);
		given_rsp_t g;
		g.has_rsp = has_rsp;
		g.rsp = rsp;
		given_rsp_q.push_back(g);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sent_count++;
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (received_count < sent_count)
			@(posedge clk);
	endtask

	function automatic void report_error(input string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("%s", msg);
	endfunction

	always @(posedge clk) begin
		rsp_ch.ready <= !(receiver_stall_pct != 0 && $urandom_range(99) < receiver_stall_pct);
	end

	// Checks results first, then records the expectation of a newly accepted request.
	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		given_rsp_t g;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				received_count++;
				if (pending_rsp_q.size() == 0) begin
					report_error($sformatf("unexpected result transfer: tgt=%0d idx=%0d",
						got.target, got.entry_index));
				end else begin
					want = pending_rsp_q.pop_front();
					if (got.target !== want.target || got.entry_index !== want.entry_index ||
							got.allocate !== want.allocate ||
							got.release_res !== want.release_res ||
							got.fill_red !== want.fill_red ||
							got.fill_green !== want.fill_green ||
							got.fill_blue !== want.fill_blue)
						report_error($sformatf({"mismatch: expected tgt=%0d idx=%0d alloc=%b ",
							"rel=%b fill=%h_%h_%h, actual tgt=%0d idx=%0d alloc=%b rel=%b ",
							"fill=%h_%h_%h"}, want.target, want.entry_index, want.allocate,
							want.release_res, want.fill_red, want.fill_green, want.fill_blue,
							got.target, got.entry_index, got.allocate, got.release_res,
							got.fill_red, got.fill_green, got.fill_blue));
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				g = given_rsp_q.pop_front();
				want = resolve_color(req_ch.data);
				pending_rsp_q.push_back(g.has_rsp ? g.rsp : want);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		index_seen = '0;
		fifo_ptr = 0;
		for (int i = 0; i < RGB_SLOTS; i++) begin
			slot_key[i] = '0;
			slot_valid[i] = 1'b0;
		end
		for (int i = 0; i < 96; i++)
			color_pool[i] = 24'($urandom);

		color_table[0] = make_row(MODE_BASIC, 8'd30, 24'h0, 1, TGT_PALETTE, 8'd0, 0, 0, 24'h0);
		color_table[1] = make_row(MODE_BASIC, 8'd37, 24'hffffff, 1, TGT_PALETTE, 8'd7, 0, 0,
			24'h0);
		color_table[2] = make_row(MODE_BASIC, 8'd40, 24'h0, 1, TGT_PALETTE, 8'd0, 0, 0, 24'h0);
		color_table[3] = make_row(MODE_BASIC, 8'd47, 24'h0, 1, TGT_PALETTE, 8'd7, 0, 0, 24'h0);
		color_table[4] = make_row(MODE_BASIC, 8'd29, 24'h0, 1, TGT_WHITE, 8'd0, 0, 0, 24'h0);
		color_table[5] = make_row(MODE_BASIC, 8'd255, 24'hffffff, 1, TGT_WHITE, 8'd0, 0, 0,
			24'h0);
		color_table[6] = make_row(MODE_BRIGHT, 8'd90, 24'h0, 1, TGT_PALETTE, 8'd8, 0, 0, 24'h0);
		color_table[7] = make_row(MODE_BRIGHT, 8'd107, 24'h0, 1, TGT_PALETTE, 8'd15, 0, 0,
			24'h0);
		color_table[8] = make_row(MODE_BRIGHT, 8'd98, 24'h0, 1, TGT_WHITE, 8'd0, 0, 0, 24'h0);
		color_table[9] = make_row(MODE_BRIGHT, 8'd0, 24'h0, 1, TGT_WHITE, 8'd0, 0, 0, 24'h0);
		color_table[10] = make_row(MODE_INDEXED, 8'd0, 24'h0, 1, TGT_PALETTE, 8'd0, 0, 0, 24'h0);
		color_table[11] = make_row(MODE_INDEXED, 8'd15, 24'h0, 1, TGT_PALETTE, 8'd15, 0, 0,
			24'h0);
		color_table[12] = make_row(MODE_INDEXED, 8'd16, 24'h0, 1, TGT_INDEXED, 8'd16, 1, 0,
			24'h0);
		color_table[13] = make_row(MODE_INDEXED, 8'd16, 24'h0, 1, TGT_INDEXED, 8'd16, 0, 0,
			24'h0);
		color_table[14] = make_row(MODE_INDEXED, 8'd231, 24'h0, 1, TGT_INDEXED, 8'd231, 1, 0,
			24'hffffff);
		color_table[15] = make_row(MODE_INDEXED, 8'd232, 24'h0, 1, TGT_INDEXED, 8'd232, 1, 0,
			24'h080808);
		color_table[16] = make_row(MODE_INDEXED, 8'd255, 24'h0, 1, TGT_INDEXED, 8'd255, 1, 0,
			24'heeeeee);
		color_table[17] = make_row(MODE_INDEXED, 8'd196, 24'h0, 0, TGT_WHITE, 8'd0, 0, 0, 24'h0);
		color_table[18] = make_row(MODE_RGB, 8'd0, 24'h000000, 1, TGT_RGB, 8'd0, 1, 0, 24'h0);
		color_table[19] = make_row(MODE_RGB, 8'd255, 24'hffffff, 1, TGT_RGB, 8'd1, 1, 0,
			24'hffffff);
		color_table[20] = make_row(MODE_RGB, 8'd0, 24'h000000, 1, TGT_RGB, 8'd0, 0, 0, 24'h0);
		color_table[21] = make_row(MODE_RGB, 8'd7, 24'h123456, 0, TGT_WHITE, 8'd0, 0, 0, 24'h0);
		color_table[22] = make_row(MODE_OTHER, 8'd33, 24'h0, 1, TGT_WHITE, 8'd0, 0, 0, 24'h0);
		color_table[23] = make_row(3'd7, 8'd255, 24'hffffff, 1, TGT_WHITE, 8'd0, 0, 0, 24'h0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 24; i++)
			send_request(color_table[i].stim, color_table[i].has_rsp, color_table[i].rsp);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
			1: begin
				sender_idle_pct = 82;
				receiver_stall_pct = 0;
			end
			2: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 82;
			end
			default: begin
				sender_idle_pct = 19;
				receiver_stall_pct = 19;
			end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				send_request(random_request(), 1'b0, '0);
			// Hold off the next transfer until every result of this phase is back.
			wait_drained();
		end

		receiver_stall_pct = 0;
		repeat (RGB_SLOTS + 10) @(posedge clk);
		if (pending_rsp_q.size() != 0)
			report_error($sformatf("%0d results never arrived", pending_rsp_q.size()));
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

>>> color_slot_resolver_fifo_cache.f
+incdir+rtl
rtl/cslr_pkg.sv
rtl/cslr_chan_if.sv
rtl/cslr_front.sv
rtl/cslr_queue.sv
rtl/cslr_back.sv
rtl/color_slot_resolver_fifo_cache.sv
verif/testbench.sv
